// ===== rtl/nsfcc_pkg.sv =====
`timescale 1ns / 1ps

package nsfcc_pkg;

   localparam int FLAG_W = 16;
   localparam int CNT_W  = 4;
   localparam int CMD_W  = 8;
   localparam int TIME_W = 32;
   // Whole seconds of a 32-bit millisecond time fit in 22 bits of magnitude.
   localparam int QUO_W  = 22;
   localparam int SEC_W  = QUO_W + 1;
   localparam int LAST_W = 16;

   localparam logic [CNT_W-1:0] CNT_MAX = 4'hF;
   localparam int unsigned MS_PER_SEC = 1000;
   // floor(2^40 / 1000); the estimate is low by at most one.
   localparam int RECIP_SHIFT = 40;
   localparam logic [30:0] RECIP = 31'd1099511627;

   // Flag bit positions.
   localparam int F_OFF      = 0;
   localparam int F_STANDBY  = 1;
   localparam int F_ACTIVE   = 2;
   localparam int F_PRECLAIM = 3;
   localparam int F_CLAIM    = 4;
   localparam int F_CLAIMED  = 5;
   localparam int F_FALSEALV = 6;
   localparam int F_CAUSED   = 7;
   localparam int F_AFFECTED = 8;

   localparam logic [FLAG_W-1:0] M_OFF_SB = 16'h0003;
   localparam logic [FLAG_W-1:0] M_ACTIVE = 16'h0004;
   localparam logic [FLAG_W-1:0] M_CLAIM_GROUP = 16'h0078;

   // Counter command codes.
   localparam logic signed [CMD_W-1:0] CMD_DEC = -8'sd3;
   localparam logic signed [CMD_W-1:0] CMD_INC = -8'sd2;
   localparam logic signed [CMD_W-1:0] CMD_REQ = -8'sd1;

   typedef enum logic [2:0] {
      OP_SET_FLAGS = 3'd0,
      OP_CLAIM     = 3'd1,
      OP_ALIVE     = 3'd2,
      OP_CAUSED    = 3'd3,
      OP_AFFECTED  = 3'd4
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic [FLAG_W-1:0]        flags_in;
      logic                     clear_old;
      logic signed [CMD_W-1:0]  count_cmd;
   } cmd_type;

   typedef struct packed {
      logic [FLAG_W-1:0] flags;
      logic [CNT_W-1:0]  count;
      logic [LAST_W-1:0] last;
   } conf_type;

endpackage

// ===== rtl/nsfcc_sec_div.sv =====
`timescale 1ns / 1ps

// Three-stage pipeline that turns a signed millisecond time into whole
// seconds, truncated toward zero, and carries the command alongside.
module nsfcc_sec_div import nsfcc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  cmd_type                  in_cmd,
   input  logic signed [TIME_W-1:0] in_time,
   output logic                     out_valid,
   input  logic                     out_ready,
   output cmd_type                  out_cmd,
   output logic signed [SEC_W-1:0]  out_sec
);

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic en1, en2, en3;

   cmd_type             cmd1_ff, cmd2_ff, cmd3_ff;
   logic                neg1_ff, neg2_ff;
   logic [TIME_W-1:0]   mag1_ff, mag1_in, mag2_ff;
   logic [QUO_W-1:0]    quo2_ff;
   logic signed [SEC_W-1:0] sec3_ff, sec3_in;

   logic [62:0]         prod;
   logic [TIME_W-1:0]   rem;
   logic [QUO_W-1:0]    quo;

   assign en3 = !v3_ff || out_ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign in_ready = en1;

   assign v1_in = en1 ? in_valid : v1_ff;
   assign v2_in = en2 ? v1_ff : v2_ff;
   assign v3_in = en3 ? v2_ff : v3_ff;

   assign mag1_in = in_time[TIME_W-1] ? TIME_W'(-in_time) : TIME_W'(in_time);

   assign prod = 63'(mag1_ff) * 63'(RECIP);

   // The estimate from the reciprocal is at most one short of the quotient.
   always_comb begin
      rem = mag2_ff - TIME_W'(TIME_W'(quo2_ff) * TIME_W'(MS_PER_SEC));
      quo = (rem >= TIME_W'(MS_PER_SEC)) ? quo2_ff + QUO_W'(1) : quo2_ff;
      sec3_in = neg2_ff ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         cmd1_ff <= in_cmd;
         neg1_ff <= in_time[TIME_W-1];
         mag1_ff <= mag1_in;
      end
      if (en2) begin
         cmd2_ff <= cmd1_ff;
         neg2_ff <= neg1_ff;
         mag2_ff <= mag1_ff;
         quo2_ff <= prod[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
      end
      if (en3) begin
         cmd3_ff <= cmd2_ff;
         sec3_ff <= sec3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_cmd   = cmd3_ff;
   assign out_sec   = sec3_ff;

endmodule

// ===== rtl/node_state_flags_and_conflict_counters.sv =====
`timescale 1ns / 1ps
// Throughput: one beat per cycle unless the result side stalls. The seconds
// divider runs in three pipeline stages ahead of a single stage that updates
// the flags and counters, and each request beat passes through all of them.
// Reset (synchronous, active high) clears the flag word, all counters, both
// stored seconds and every valid bit; the block is ready in the next cycle.
module node_state_flags_and_conflict_counters import nsfcc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [15:0] flags_in, [16] clear_old, [24:17] count_cmd, [56:25] time_ms
   input  logic [63:0] req_tdata,
   // [2:0] op
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] flags_out, [19:16] count_out
   output logic [23:0] rsp_tdata
);

   cmd_type                 in_cmd, d_cmd;
   logic                    d_valid, d_ready, take;
   logic signed [SEC_W-1:0] d_sec;

   logic [FLAG_W-1:0] flag_ff, flag_in;
   logic [CNT_W-1:0]  claim_ff, claim_in, alive_ff, alive_in;
   logic [CNT_W-1:0]  caused_ff, caused_in, affected_ff, affected_in;
   logic [LAST_W-1:0] caused_sec_ff, caused_sec_in, affected_sec_ff, affected_sec_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [FLAG_W-1:0] rsp_flags_ff;
   logic [CNT_W-1:0]  rsp_count_ff, count_in;
   conf_type          conf;

   function automatic logic [FLAG_W-1:0] apply_flags(input logic [FLAG_W-1:0] w_old,
                                                     input logic [FLAG_W-1:0] f,
                                                     input logic replace);
      logic [FLAG_W-1:0] w;
      w = replace ? f : w_old;
      if ((f & (M_ACTIVE | M_CLAIM_GROUP)) != '0) begin
         w = w & ~M_OFF_SB;
         if ((f & M_CLAIM_GROUP) != '0) begin
            w = w & ~M_CLAIM_GROUP;
         end
         w = w | M_ACTIVE;
      end
      if ((f & M_OFF_SB) != '0) begin
         w = w & ~(M_OFF_SB | M_ACTIVE);
      end
      return w | f;
   endfunction

   function automatic conf_type conflict_op(input logic signed [CMD_W-1:0] cmd,
                                            input logic signed [SEC_W-1:0] sec,
                                            input logic [FLAG_W-1:0] flags,
                                            input logic [CNT_W-1:0] cnt,
                                            input logic [LAST_W-1:0] last,
                                            input logic [FLAG_W-1:0] flag_mask);
      conf_type r;
      r.flags = flags;
      r.count = cnt;
      r.last  = last;
      if (cmd == CMD_INC) begin
         r.last = sec[LAST_W-1:0];
         if (cnt != CNT_MAX) begin
            r.count = cnt + CNT_W'(1);
         end
      end else if (cmd == CMD_DEC) begin
         // The stored second is compared sign-extended against the full quotient.
         if (cnt != '0 && sec != $signed({{(SEC_W-LAST_W){last[LAST_W-1]}}, last})) begin
            r.count = cnt - CNT_W'(1);
         end
      end else if (cmd != CMD_REQ) begin
         if (cmd > 0) begin
            r.flags = apply_flags(flags, flag_mask, 1'b0);
         end else begin
            r.flags = flags & ~flag_mask;
         end
         if (!cmd[CMD_W-1] && cmd < $signed({4'b0, CNT_MAX})) begin
            r.count = cmd[CNT_W-1:0];
         end
      end
      return r;
   endfunction

   assign in_cmd.op        = op_type'(req_tuser);
   assign in_cmd.flags_in  = req_tdata[15:0];
   assign in_cmd.clear_old = req_tdata[16];
   assign in_cmd.count_cmd = $signed(req_tdata[24:17]);

   nsfcc_sec_div u_sec_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (in_cmd),
      .in_time   ($signed(req_tdata[56:25])),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_cmd   (d_cmd),
      .out_sec   (d_sec)
   );

   assign d_ready = !rsp_valid_ff || rsp_tready;
   assign take    = d_valid && d_ready;

   always_comb begin
      flag_in         = flag_ff;
      claim_in        = claim_ff;
      alive_in        = alive_ff;
      caused_in       = caused_ff;
      affected_in     = affected_ff;
      caused_sec_in   = caused_sec_ff;
      affected_sec_in = affected_sec_ff;
      count_in        = '0;
      conf            = conflict_op(d_cmd.count_cmd, d_sec, flag_ff, caused_ff,
                                    caused_sec_ff, FLAG_W'(1) << F_CAUSED);
      case (d_cmd.op)
         OP_SET_FLAGS: begin
            flag_in = apply_flags(flag_ff, d_cmd.flags_in, d_cmd.clear_old);
         end
         OP_CLAIM: begin
            if (!d_cmd.count_cmd[CMD_W-1]) begin
               flag_in  = apply_flags(flag_ff, FLAG_W'(1) << F_CLAIM, 1'b0);
               claim_in = d_cmd.count_cmd[CNT_W-1:0];
            end
            count_in = flag_in[F_CLAIM] ? claim_in : '0;
         end
         OP_ALIVE: begin
            if (d_cmd.count_cmd == CMD_INC) begin
               if (alive_ff != CNT_MAX) alive_in = alive_ff + CNT_W'(1);
            end else if (d_cmd.count_cmd == CMD_DEC) begin
               if (alive_ff != '0) alive_in = alive_ff - CNT_W'(1);
            end else if (!d_cmd.count_cmd[CMD_W-1] &&
                         d_cmd.count_cmd < $signed({4'b0, CNT_MAX})) begin
               alive_in = d_cmd.count_cmd[CNT_W-1:0];
            end
            count_in = flag_ff[F_FALSEALV] ? alive_in : '0;
         end
         OP_CAUSED: begin
            flag_in       = conf.flags;
            caused_in     = conf.count;
            caused_sec_in = conf.last;
            count_in      = flag_in[F_CAUSED] ? caused_in : '0;
         end
         OP_AFFECTED: begin
            conf            = conflict_op(d_cmd.count_cmd, d_sec, flag_ff, affected_ff,
                                          affected_sec_ff, FLAG_W'(1) << F_AFFECTED);
            flag_in         = conf.flags;
            affected_in     = conf.count;
            affected_sec_in = conf.last;
            count_in        = flag_in[F_AFFECTED] ? affected_in : '0;
         end
         default: begin
            count_in = '0;
         end
      endcase
   end

   assign rsp_valid_in = take ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff         <= '0;
         claim_ff        <= '0;
         alive_ff        <= '0;
         caused_ff       <= '0;
         affected_ff     <= '0;
         caused_sec_ff   <= '0;
         affected_sec_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            flag_ff         <= flag_in;
            claim_ff        <= claim_in;
            alive_ff        <= alive_in;
            caused_ff       <= caused_in;
            affected_ff     <= affected_in;
            caused_sec_ff   <= caused_sec_in;
            affected_sec_ff <= affected_sec_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_flags_ff <= flag_in;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_count_ff, rsp_flags_ff};

endmodule

// ===== rtl/nsfcc_checker.sv =====
`timescale 1ns / 1ps

module nsfcc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // A waiting result beat holds its value until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // The request side only stalls when a result beat is held back.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled without result backpressure");

   // Nothing is left pending across reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   // The fill bits above the count are zero on every result beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:20] == 4'b0)
      else $error("result padding not zero");

endmodule

bind node_state_flags_and_conflict_counters nsfcc_checker u_nsfcc_checker (.*);

// ===== sim/tb_node_state_flags_and_conflict_counters.sv =====
`timescale 1ns / 1ps

module tb_node_state_flags_and_conflict_counters;
   import nsfcc_pkg::*;

   // Op codes that the block leaves without effect.
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int RANDOM_BEATS = 2000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [FLAG_W-1:0] flags;
      logic [CNT_W-1:0]  count;
   } node_status_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [15:0] flags_in, [16] clear_old, [24:17] count_cmd, [56:25] time_ms
   logic [63:0] req_tdata = '0;
   // [2:0] op
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [15:0] flags_out, [19:16] count_out
   logic [23:0] rsp_tdata;

   // Predicted node state.
   logic [FLAG_W-1:0] node_flags;
   logic [CNT_W-1:0]  claim_cnt, alive_cnt, caused_cnt, affected_cnt;
   logic [LAST_W-1:0] caused_sec, affected_sec;

   node_status_type node_status_q[$];
   node_status_type expected_status;
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   node_state_flags_and_conflict_counters u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic logic [FLAG_W-1:0] merged_flags(input logic [FLAG_W-1:0] cur,
                                                      input logic [FLAG_W-1:0] f,
                                                      input logic replace);
      logic [FLAG_W-1:0] w;
      w = replace ? f : cur;
      if ((f & (M_ACTIVE | M_CLAIM_GROUP)) != '0) begin
         w = w & ~M_OFF_SB;
         if ((f & M_CLAIM_GROUP) != '0) begin
            w = w & ~M_CLAIM_GROUP;
         end
         w = w | M_ACTIVE;
      end
      if ((f & M_OFF_SB) != '0) begin
         w = w & ~(M_OFF_SB | M_ACTIVE);
      end
      return w | f;
   endfunction

   task automatic update_conflict(input int cmd, input int sec,
                                  inout logic [CNT_W-1:0] cnt,
                                  inout logic [LAST_W-1:0] last,
                                  input int flag_bit);
      logic [FLAG_W-1:0] mask;
      mask = 16'h1 << flag_bit;
      if (cmd == int'(CMD_INC)) begin
         last = sec[LAST_W-1:0];
         if (cnt < CNT_MAX) cnt = cnt + 1'b1;
      end else if (cmd == int'(CMD_DEC)) begin
         // Decrement only once the second has moved on from the stored one.
         if (cnt > 0 && sec != int'($signed(last))) cnt = cnt - 1'b1;
      end else if (cmd != int'(CMD_REQ)) begin
         if (cmd > 0) node_flags = merged_flags(node_flags, mask, 1'b0);
         else node_flags = node_flags & ~mask;
         if (cmd >= 0 && cmd < int'(CNT_MAX)) cnt = cmd[CNT_W-1:0];
      end
   endtask

   task automatic predict_node_status(input logic [2:0] op, input logic [FLAG_W-1:0] fin,
                                      input logic clr, input logic signed [CMD_W-1:0] cmd,
                                      input logic signed [TIME_W-1:0] time_ms);
      int cmd_i;
      int sec;
      node_status_type st;
      cmd_i = int'(cmd);
      sec = int'(time_ms) / int'(MS_PER_SEC);
      st.count = '0;
      case (op)
         OP_SET_FLAGS: begin
            node_flags = merged_flags(node_flags, fin, clr);
         end
         OP_CLAIM: begin
            if (cmd_i >= 0) begin
               node_flags = merged_flags(node_flags, 16'h1 << F_CLAIM, 1'b0);
               claim_cnt = cmd_i[CNT_W-1:0];
            end
            st.count = node_flags[F_CLAIM] ? claim_cnt : '0;
         end
         OP_ALIVE: begin
            if (cmd_i == int'(CMD_INC)) begin
               if (alive_cnt < CNT_MAX) alive_cnt = alive_cnt + 1'b1;
            end else if (cmd_i == int'(CMD_DEC)) begin
               if (alive_cnt > 0) alive_cnt = alive_cnt - 1'b1;
            end else if (cmd_i >= 0 && cmd_i < int'(CNT_MAX)) begin
               alive_cnt = cmd_i[CNT_W-1:0];
            end
            st.count = node_flags[F_FALSEALV] ? alive_cnt : '0;
         end
         OP_CAUSED: begin
            update_conflict(cmd_i, sec, caused_cnt, caused_sec, F_CAUSED);
            st.count = node_flags[F_CAUSED] ? caused_cnt : '0;
         end
         OP_AFFECTED: begin
            update_conflict(cmd_i, sec, affected_cnt, affected_sec, F_AFFECTED);
            st.count = node_flags[F_AFFECTED] ? affected_cnt : '0;
         end
         default: ;
      endcase
      st.flags = node_flags;
      node_status_q.push_back(st);
   endtask

   task automatic send_beat(input logic [2:0] op, input logic [FLAG_W-1:0] fin,
                            input logic clr, input logic signed [CMD_W-1:0] cmd,
                            input logic signed [TIME_W-1:0] time_ms);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'b0, time_ms, cmd, clr, fin};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_node_status(op, fin, clr, cmd, time_ms);
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Each accepted result beat is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (node_status_q.size() == 0) begin
            $display("%0t: result beat with nothing expected, actual %h", $time, rsp_tdata);
            error_count++;
         end else begin
            expected_status = node_status_q.pop_front();
            if (rsp_tdata[15:0] !== expected_status.flags) begin
               $display("%0t: flags_out expected %h actual %h", $time,
                        expected_status.flags, rsp_tdata[15:0]);
               error_count++;
            end
            if (rsp_tdata[19:16] !== expected_status.count) begin
               $display("%0t: count_out expected %0d actual %0d", $time,
                        expected_status.count, rsp_tdata[19:16]);
               error_count++;
            end
         end
      end
   end

   task automatic test_flag_rules();
      send_beat(OP_SET_FLAGS, 16'h0001, 1'b1, 8'sd0, 32'sd0);
      send_beat(OP_SET_FLAGS, 16'h0002, 1'b0, 8'sd0, 32'sd0);
      send_beat(OP_SET_FLAGS, 16'h0004, 1'b0, 8'sd0, 32'sd0);
      send_beat(OP_SET_FLAGS, 16'h0048, 1'b0, 8'sd0, 32'sd0);
      send_beat(OP_SET_FLAGS, 16'hFFFF, 1'b1, 8'sd0, 32'sd0);
      send_beat(OP_SET_FLAGS, 16'h0000, 1'b1, 8'sd0, 32'sd0);
      send_beat(OP_SET_FLAGS, 16'hFE30, 1'b0, 8'sd0, 32'sd0);
   endtask

   task automatic test_claim_and_alive();
      send_beat(OP_CLAIM, 16'h0000, 1'b0, 8'sd127, 32'sd0);
      send_beat(OP_CLAIM, 16'h0000, 1'b0, CMD_REQ, 32'sd0);
      send_beat(OP_CLAIM, 16'h0000, 1'b0, -8'sd128, 32'sd0);
      send_beat(OP_SET_FLAGS, 16'h0040, 1'b0, 8'sd0, 32'sd0);
      send_beat(OP_ALIVE, 16'h0000, 1'b0, 8'sd14, 32'sd0);
      send_beat(OP_ALIVE, 16'h0000, 1'b0, CMD_INC, 32'sd0);
      send_beat(OP_ALIVE, 16'h0000, 1'b0, CMD_INC, 32'sd0);
      send_beat(OP_ALIVE, 16'h0000, 1'b0, 8'sd15, 32'sd0);
      send_beat(OP_ALIVE, 16'h0000, 1'b0, CMD_DEC, 32'sd0);
      send_beat(OP_ALIVE, 16'h0000, 1'b0, -8'sd128, 32'sd0);
   endtask

   task automatic test_conflict_counters();
      send_beat(OP_CAUSED, 16'h0000, 1'b0, 8'sd7, 32'sd0);
      send_beat(OP_CAUSED, 16'h0000, 1'b0, CMD_INC, 32'h8000_0000);
      send_beat(OP_CAUSED, 16'h0000, 1'b0, CMD_DEC, 32'h8000_0000);
      send_beat(OP_CAUSED, 16'h0000, 1'b0, CMD_DEC, 32'h7FFF_FFFF);
      send_beat(OP_CAUSED, 16'h0000, 1'b0, -8'sd128, 32'sd0);
      // A positive value past the counter range only sets the flag.
      send_beat(OP_AFFECTED, 16'h0000, 1'b0, 8'sd127, 32'sd0);
      send_beat(OP_AFFECTED, 16'h0000, 1'b0, CMD_INC, 32'sd999);
      // Truncation toward zero puts -999 ms in the same second as 999 ms.
      send_beat(OP_AFFECTED, 16'h0000, 1'b0, CMD_DEC, -32'sd999);
      send_beat(OP_AFFECTED, 16'h0000, 1'b0, CMD_DEC, 32'sd1000);
   endtask

   task automatic test_spare_ops();
      send_beat(OP_SPARE_LO, 16'hFFFF, 1'b1, CMD_INC, 32'sd0);
      send_beat(OP_SPARE_HI, 16'hFFFF, 1'b1, 8'sd3, 32'sd0);
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct, input int beats);
      logic [2:0]               op;
      logic [FLAG_W-1:0]        fin;
      logic                     clr;
      logic signed [CMD_W-1:0]  cmd;
      logic signed [TIME_W-1:0] time_ms;
      int                       time_base;
      int                       pick;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      time_base = int'($urandom);
      for (int i = 0; i < beats; i++) begin
         if ($urandom_range(99) < 5) op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
         else op = 3'($urandom_range(OP_AFFECTED, OP_SET_FLAGS));

         pick = $urandom_range(99);
         if (pick < 40) fin = 16'h1 << $urandom_range(F_AFFECTED, F_OFF);
         else if (pick < 70) fin = FLAG_W'($urandom);
         else fin = FLAG_W'($urandom & 16'h01FF & $urandom);
         clr = ($urandom_range(3) == 0);

         // Half the commands are drawn from the special codes so the counters really move.
         pick = $urandom_range(99);
         if (pick < 50) begin
            case ($urandom_range(2))
               0: cmd = CMD_DEC;
               1: cmd = CMD_INC;
               default: cmd = CMD_REQ;
            endcase
         end else if (pick < 80) begin
            cmd = CMD_W'($urandom_range(CNT_MAX));
         end else begin
            cmd = CMD_W'($urandom);
         end

         // Times mostly cluster around a base so repeated seconds are common.
         if ($urandom_range(99) < 5) time_base = int'($urandom);
         if ($urandom_range(99) < 15) time_ms = $urandom;
         else time_ms = time_base + int'($urandom_range(2999)) - 1500;

         send_beat(op, fin, clr, cmd, time_ms);
      end
   endtask

   initial begin
      node_flags   = '0;
      claim_cnt    = '0;
      alive_cnt    = '0;
      caused_cnt   = '0;
      affected_cnt = '0;
      caused_sec   = '0;
      affected_sec = '0;
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_flag_rules();
      test_claim_and_alive();
      test_conflict_counters();
      test_spare_ops();
      test_random_traffic(24, 79, RANDOM_BEATS / 3);
      test_random_traffic(79, 24, RANDOM_BEATS / 3);
      test_random_traffic(0, 0, RANDOM_BEATS - 2 * (RANDOM_BEATS / 3));
      req_tvalid <= 1'b0;

      while (node_status_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && node_status_q.size() == 0) begin
         $display("tb_node_state_flags_and_conflict_counters: PASS");
      end else begin
         $display("tb_node_state_flags_and_conflict_counters: FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_node_state_flags_and_conflict_counters: FAIL");
      $finish;
   end

endmodule
